@@ rtl/core/crt_pkg.sv @@
// crt_pkg: shared types and constants for the CPU id remap table.
// Used by crt_datapath, crt_ctrl and cpu_id_remap_table.
package crt_pkg;

    // Payload and register widths
    localparam int MODE_W   = 3;
    localparam int THREAD_W = 16;
    localparam int CPU_W    = 10;
    localparam int OFF_W    = 8;
    localparam int NODE_W   = 4;
    localparam int TPN_W    = 11;

    // Slot word: stored thread id (one bit wider than a thread id) and in-use mark
    localparam int SLOT_TW  = THREAD_W + 1;
    localparam int SLOT_MW  = SLOT_TW + 1;

    localparam logic [SLOT_TW-1:0] THREAD_VACANT = {SLOT_TW{1'b1}};

    // Default slots per node: threads per core times cores per node
    localparam int THREADS_PER_CORE = 8;
    localparam int CORES_PER_NODE   = 32;
    localparam logic [TPN_W-1:0] TPN_RESET = TPN_W'(THREADS_PER_CORE * CORES_PER_NODE);

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_MAP     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIND    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd4;

    // Operation held while an item is in flight
    typedef enum logic [2:0] {
        OP_MAP,
        OP_FIND,
        OP_GET,
        OP_RESERVE,
        OP_RELEASE,
        OP_NONE
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic accept;
        logic probe;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic done;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/core/crt_slot_mem.sv @@
// crt_slot_mem: slot table storage, one write port and one registered read port.
// Standalone; no package dependency.
module crt_slot_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 18
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/crt_datapath.sv @@
// crt_datapath: start slot, probe pointer, slot compare, clearing sweep and result registers.
// Depends on crt_pkg and crt_slot_mem.
module crt_datapath
    import crt_pkg::*;
#(
    parameter int CPU_COUNT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_dp_status          o_status,
    input  logic [TPN_W-1:0]    i_tpn,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [THREAD_W-1:0] i_thread_id,
    input  logic [CPU_W-1:0]    i_cpu_index,
    input  logic [OFF_W-1:0]    i_core_offset,
    input  logic [NODE_W-1:0]   i_node_id,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_ok,
    output logic [CPU_W-1:0]    o_cpu_out,
    output logic [THREAD_W-1:0] o_thread_out
);

    localparam int SW   = $clog2(CPU_COUNT);
    localparam int CNTW = $clog2(CPU_COUNT + 1);
    localparam logic [15:0]   COUNT16   = 16'(CPU_COUNT);
    localparam logic [SW-1:0] LAST_SLOT = SW'(CPU_COUNT - 1);

    // In-flight item
    t_op                 r_op;
    logic [THREAD_W-1:0] r_thr;
    logic [SW-1:0]       r_ptr;
    logic [CNTW-1:0]     r_iss_left;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic [SW-1:0]       r_rd_slot;
    logic [SW-1:0]       r_clr_cnt;

    // Pending and output results
    logic                r_res_ok;
    logic [CPU_W-1:0]    r_res_cpu;
    logic [THREAD_W-1:0] r_res_thr;
    logic                r_out_vld;
    logic                r_out_ok;
    logic [CPU_W-1:0]    r_out_cpu;
    logic [THREAD_W-1:0] r_out_thr;

    logic [15:0]         w_map_base;
    logic [SW-1:0]       w_start;
    t_op                 w_op;
    logic [SW-1:0]       w_next_ptr;
    logic                w_issue;
    logic [SLOT_MW-1:0]  w_rd_data;
    logic [SLOT_TW-1:0]  w_rd_thread;
    logic                w_rd_in_use;
    logic                w_match;
    logic                w_hit;
    logic                w_writes;
    logic                w_done;
    logic                w_wr_en;
    logic [SW-1:0]       w_wr_addr;
    logic [SLOT_MW-1:0]  w_wr_data;
    logic [SLOT_MW-1:0]  w_upd_data;
    logic [CPU_W-1:0]    w_cpu_res;
    logic [THREAD_W-1:0] w_thr_res;

    // Decode the accepted item and its first slot
    always_comb begin
        w_map_base = 16'(i_node_id) * 16'(i_tpn) + 16'(i_core_offset);
        w_op       = OP_NONE;
        w_start    = '0;
        unique case (i_mode)
            MODE_MAP: begin
                w_op = OP_MAP;
                if (w_map_base < COUNT16) begin
                    w_start = SW'(w_map_base);
                end else if (16'(i_core_offset) < COUNT16) begin
                    w_start = SW'(i_core_offset);
                end
            end
            MODE_FIND: begin
                w_op = OP_FIND;
                if (16'(i_thread_id) < COUNT16) begin
                    w_start = SW'(i_thread_id);
                end
            end
            MODE_GET, MODE_RESERVE, MODE_RELEASE: begin
                if (16'(i_cpu_index) < COUNT16) begin
                    w_start = SW'(i_cpu_index);
                    if (i_mode == MODE_GET) begin
                        w_op = OP_GET;
                    end else if (i_mode == MODE_RESERVE) begin
                        w_op = OP_RESERVE;
                    end else begin
                        w_op = OP_RELEASE;
                    end
                end
            end
            default: begin
                w_op = OP_NONE;
            end
        endcase
    end

    // Probe pointer: one slot read per cycle, wrapping at the top slot
    assign w_next_ptr = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
    assign w_issue    = i_cmd.probe && (r_iss_left != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_left <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (i_cmd.accept) begin
                r_iss_left <= (w_op == OP_MAP || w_op == OP_FIND) ?
                              CNTW'(CPU_COUNT) : CNTW'(1);
            end else if (w_issue) begin
                r_iss_left <= r_iss_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= w_op;
            r_thr <= i_thread_id;
            r_ptr <= w_start;
        end else if (w_issue) begin
            r_ptr <= w_next_ptr;
        end
        r_rd_last <= (r_iss_left == CNTW'(1));
        r_rd_slot <= r_ptr;
    end

    // Evaluate the slot that came back from memory
    assign w_rd_thread = w_rd_data[SLOT_MW-1:1];
    assign w_rd_in_use = w_rd_data[0];
    assign w_match     = (w_rd_thread == {1'b0, r_thr});

    always_comb begin
        w_hit      = 1'b0;
        w_writes   = 1'b0;
        w_upd_data = w_rd_data;
        w_cpu_res  = '0;
        w_thr_res  = '0;
        unique case (r_op)
            OP_MAP: begin
                w_hit      = !w_rd_in_use || w_match;
                w_writes   = 1'b1;
                w_upd_data = {1'b0, r_thr, w_rd_in_use};
                w_cpu_res  = CPU_W'(r_rd_slot);
            end
            OP_FIND: begin
                w_hit     = w_rd_in_use && w_match;
                w_cpu_res = CPU_W'(r_rd_slot);
            end
            OP_GET: begin
                w_hit     = w_rd_in_use;
                w_thr_res = w_rd_thread[THREAD_W-1:0];
            end
            OP_RESERVE: begin
                w_hit      = !w_rd_in_use;
                w_writes   = 1'b1;
                w_upd_data = {w_rd_thread, 1'b1};
                w_cpu_res  = CPU_W'(r_rd_slot);
            end
            OP_RELEASE: begin
                w_hit      = w_rd_in_use;
                w_writes   = 1'b1;
                w_upd_data = {w_rd_thread, 1'b0};
                w_cpu_res  = CPU_W'(r_rd_slot);
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    assign w_done = i_cmd.probe && r_rd_vld && (w_hit || r_rd_last);

    // Memory write: clearing sweep after reset, else the update of a hit slot
    always_comb begin
        if (i_cmd.clear) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_cnt;
            w_wr_data = {THREAD_VACANT, 1'b0};
        end else begin
            w_wr_en   = w_done && w_hit && w_writes;
            w_wr_addr = r_rd_slot;
            w_wr_data = w_upd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    crt_slot_mem #(
        .DEPTH (CPU_COUNT),
        .AW    (SW),
        .DW    (SLOT_MW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_ptr),
        .o_rd_data (w_rd_data)
    );

    // Hold the finished result until the output register is free
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_res_ok  <= w_hit;
            r_res_cpu <= w_hit ? w_cpu_res : '0;
            r_res_thr <= w_hit ? w_thr_res : '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_ok  <= r_res_ok;
            r_out_cpu <= r_res_cpu;
            r_out_thr <= r_res_thr;
        end
    end

    assign o_status.clr_last = (r_clr_cnt == LAST_SLOT);
    assign o_status.done     = w_done;
    assign o_status.out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid  = r_out_vld;
    assign o_ok         = r_out_ok;
    assign o_cpu_out    = r_out_cpu;
    assign o_thread_out = r_out_thr;

endmodule

@@ rtl/core/crt_ctrl.sv @@
// crt_ctrl: state machine that sequences clearing, accept, probe and result hand-off.
// Depends on crt_pkg.
module crt_ctrl
    import crt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_status.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd.clear    = (r_state == ST_CLEAR);
        o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.probe    = (r_state == ST_PROBE);
        o_cmd.load_out = (r_state == ST_DONE) && i_status.out_free;
        o_in_stall     = (r_state != ST_IDLE);
    end

endmodule

@@ rtl/core/cpu_id_remap_table.sv @@
// cpu_id_remap_table: top level, register port and wiring of controller and datapath.
// Depends on crt_pkg, crt_ctrl and crt_datapath.
// Sequence: accept in idle, then probe with one slot-table read per probe cycle over the slots
// examined (1 for get-thread, reserve, release; up to CPU_COUNT for map and find), then hand-off.
// Input stalls from accept until hand-off, so a new item waits until the last one is through.
// Results sit in an output register, so the next item is taken while one waits.
// Reset: the slot table is cleared by a sweep over every slot; input stalls meanwhile.
module cpu_id_remap_table
    import crt_pkg::*;
#(
    parameter int CPU_COUNT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [THREAD_W-1:0] i_thread_id,
    input  logic [CPU_W-1:0]    i_cpu_index,
    input  logic [OFF_W-1:0]    i_core_offset,
    input  logic [NODE_W-1:0]   i_node_id,
    // Output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_ok,
    output logic [CPU_W-1:0]    o_cpu_out,
    output logic [THREAD_W-1:0] o_thread_out,
    // Register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [TPN_W-1:0] r_tpn;
    t_ctrl_cmd        w_cmd;
    t_dp_status       w_status;
    logic             w_tpn_sel;

    // Register 0 at byte addresses 0 to 3; addresses 4 to 7 read as zero
    assign w_tpn_sel = (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = w_tpn_sel ? 32'(r_tpn) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpn <= TPN_RESET;
        end else if (psel && penable && pwrite && pready && w_tpn_sel) begin
            r_tpn <= pwdata[TPN_W-1:0];
        end
    end

    crt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    crt_datapath #(
        .CPU_COUNT (CPU_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_tpn         (r_tpn),
        .i_mode        (i_mode),
        .i_thread_id   (i_thread_id),
        .i_cpu_index   (i_cpu_index),
        .i_core_offset (i_core_offset),
        .i_node_id     (i_node_id),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_ok          (o_ok),
        .o_cpu_out     (o_cpu_out),
        .o_thread_out  (o_thread_out)
    );

endmodule
